[rtl/assert_macros.svh]
// assertion helpers shared by the rtl files
// all checks sample on the rising edge of clk and are held off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every enabled clock edge
`define CHECK_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// when ante holds, cons holds on the following edge
`define CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mms_pkg.sv]
// ----------------------------------------------------------------------------
// mms_pkg
// types, constants and helper functions of the mouse motion smoother
// ----------------------------------------------------------------------------
`default_nettype none

package mms_pkg;

  // history window
  localparam int MAX_WINDOW = 16;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int FILL_W     = $clog2(MAX_WINDOW + 1);

  // two lanes: horizontal and vertical
  localparam int LANES = 2;

  // stream and config widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 3;

  // divider: 32-bit dividend, 8-bit divisor, two quotient bits per cycle
  localparam int DIV_W      = 32;
  localparam int DEN_W      = 8;
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // magnitude widths along the scaling chain
  localparam int SUM_W   = 21;
  localparam int MAG_W   = 39;
  localparam int PROD_W  = 48;
  localparam int MOVE_W  = 24;
  localparam int ANGLE_W = 25;

  localparam logic [31:0]       MAG_CAP      = 32'h8000_0000;
  localparam logic [MOVE_W-1:0] MOVE_POS_MAG = 24'h7F_FFFF;
  localparam logic [MOVE_W-1:0] MOVE_NEG_MAG = 24'h80_0000;

  // a full turn is 45 units of 2048 (Q9.8 degrees)
  localparam int YAW_LOW_W   = 11;
  localparam int TURN_UNITS  = 45;
  localparam int TURN_STEPS  = 8;
  localparam int TURN_OFFSET = TURN_UNITS * 128;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FILTER_ENABLE    = 3'd0,
    CFG_FILTER_FRAMES    = 3'd1,
    CFG_REFERENCE_FOV    = 3'd2,
    CFG_SENSITIVITY      = 3'd3,
    CFG_YAW_GAIN         = 3'd4,
    CFG_PITCH_GAIN       = 3'd5,
    CFG_PITCH_LIMIT_DOWN = 3'd6,
    CFG_PITCH_LIMIT_UP   = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV_AVG,
    ST_FOV_MUL,
    ST_DIV_FOV,
    ST_SENS_MUL,
    ST_GAIN_MUL,
    ST_SAT,
    ST_STEER,
    ST_WRAP,
    ST_DONE
  } state_t;

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] r,
                                               input logic b,
                                               input logic [DEN_W-1:0] d);
    logic [DEN_W:0] t;
    logic [DEN_W:0] dd;
    t  = {r, b};
    dd = {1'b0, d};
    if (t >= dd) begin
      div_step = {1'b1, DEN_W'(t - dd)};
    end else begin
      div_step = {1'b0, t[DEN_W-1:0]};
    end
  endfunction

  // previous ring slot
  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    if (s == '0) begin
      slot_dec = SLOT_W'(MAX_WINDOW - 1);
    end else begin
      slot_dec = s - 1'b1;
    end
  endfunction

  // next ring slot
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(MAX_WINDOW - 1)) begin
      slot_inc = '0;
    end else begin
      slot_inc = s + 1'b1;
    end
  endfunction

  // yaw wrapped into [0, 92160): unit index mod 45, low 11 bits kept
  function automatic logic [16:0] wrap_yaw(input logic signed [ANGLE_W-1:0] v);
    logic [13:0] q;
    logic [13:0] u;
    int k;
    q = v[ANGLE_W-1:YAW_LOW_W];
    u = 14'(q + 14'(TURN_OFFSET));
    for (k = TURN_STEPS - 1; k >= 0; k--) begin
      if (u >= 14'(TURN_UNITS << k)) begin
        u = u - 14'(TURN_UNITS << k);
      end
    end
    wrap_yaw = {u[5:0], v[YAW_LOW_W-1:0]};
  endfunction

endpackage

`default_nettype wire

[rtl/mouse_motion_smoother.sv]
// ----------------------------------------------------------------------------
// mouse_motion_smoother
// windowed average of pointer deltas, zoom/sensitivity/gain scaling, yaw/pitch
// ----------------------------------------------------------------------------
// usage
//   s_* carries one frame of pointer motion per beat: deltas, current field of
//   view, current yaw and pitch in tdata, the steer flag in tuser.
//   m_* returns one beat per input beat: saturated yaw and pitch moves plus the
//   new yaw (wrapped into a full turn) and the new pitch (clamped when steering).
//   cfg_we/cfg_addr/cfg_data write the eight setup registers; write them only
//   while no beat is in flight. writing filter_frames restarts the average.
// throughput and timing
//   one beat at a time. the time from accept to result grows with the number
//   of samples averaged, and with the zoom division when current and
//   reference field of view differ and the reference is nonzero; the history
//   reads (one ring entry per cycle) and the two-bit-per-cycle dividers set this.
// reset
//   rst clears the sequencer, the fill count, the newest slot and the setup
//   registers to their defaults. the history ring is not cleared: only entries
//   written since the last restart are ever read.
// stall
//   a finished result waits in the output register; the next input beat is
//   taken meanwhile, and a second result waits in the done state until the
//   output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mouse_motion_smoother
  import mms_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // delta_x[15:0] delta_y[31:16] current_fov[39:32] yaw_in[56:40]
  // pitch_in[73:57] zero pad[79:74]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // steer_view[0]
  input  wire logic                  s_tuser,
  // output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // yaw_move[23:0] pitch_move[47:24] yaw_out[64:48] pitch_out[81:65]
  // zero pad[87:82]
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // register write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  // setup registers
  logic        filter_enable;
  logic [4:0]  filter_frames;
  logic [7:0]  reference_fov;
  logic [15:0] sensitivity;
  logic [15:0] yaw_gain;
  logic [15:0] pitch_gain;
  logic [14:0] pitch_limit_down;
  logic [14:0] pitch_limit_up;

  // window bookkeeping
  logic [FILL_W-1:0] fill_count;
  logic [SLOT_W-1:0] newest_slot;
  logic [FILL_W-1:0] win_len;
  logic [FILL_W-1:0] fill_inc;
  logic [FILL_W-1:0] fill_new;
  logic [SLOT_W-1:0] slot_new;

  // sequencer
  state_t state;
  state_t state_next;
  logic   accept;
  logic   rd_en;
  logic   out_load;
  logic   read_done;
  logic   div_last;
  logic   fov_scale;

  // history ring: {delta_y, delta_x} per slot
  logic [31:0]       hist_mem [MAX_WINDOW];
  logic [31:0]       rd_data;
  logic [SLOT_W-1:0] rd_addr;
  logic [FILL_W-1:0] rd_left;
  logic              rd_vld;

  // latched item fields
  logic [7:0]  cur_fov;
  logic [16:0] yaw_in;
  logic [16:0] pitch_in;
  logic        steer;

  // per-lane datapath (lane 0 horizontal, lane 1 vertical)
  logic signed [SUM_W-1:0]  sum       [LANES];
  logic [SUM_W-2:0]         sum_abs   [LANES];
  logic [FILL_W-1:0]        div_n;
  logic [DEN_W-1:0]         den;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic [DIV_W-1:0]         dq        [LANES];
  logic [DEN_W-1:0]         rem       [LANES];
  logic [DEN_W:0]           div_a     [LANES];
  logic [DEN_W:0]           div_b     [LANES];
  logic                     sgn       [LANES];
  logic                     fsgn      [LANES];
  logic [MAG_W-1:0]         mag       [LANES];
  logic [46:0]              sens_prod [LANES];
  logic [15:0]              lane_gain [LANES];
  logic [15:0]              gmag      [LANES];
  logic [31:0]              mag_clamp [LANES];
  logic [PROD_W-1:0]        gain_prod [LANES];
  logic [PROD_W-1:0]        prod      [LANES];
  logic [39:0]              prod_sh   [LANES];
  logic [MOVE_W-1:0]        move_lim  [LANES];
  logic [MOVE_W-1:0]        move_mag  [LANES];
  logic [MOVE_W-1:0]        move      [LANES];

  // angle update
  logic signed [ANGLE_W-1:0] yaw_v;
  logic signed [ANGLE_W-1:0] pitch_sum;
  logic signed [ANGLE_W-1:0] lim_dn;
  logic signed [ANGLE_W-1:0] lim_up;
  logic [16:0]               pitch_res;
  logic [16:0]               yaw_res;

  // --------------------------------------------------------------------------
  // window length and ring pointer update for the accepted beat
  // --------------------------------------------------------------------------
  always_comb begin
    if (filter_frames == '0) begin
      win_len = FILL_W'(1);
    end else if (FILL_W'(filter_frames) > FILL_W'(MAX_WINDOW)) begin
      win_len = FILL_W'(MAX_WINDOW);
    end else begin
      win_len = FILL_W'(filter_frames);
    end
    fill_inc = (fill_count < win_len) ? fill_count + 1'b1 : fill_count;
    fill_new = (fill_inc > win_len) ? win_len : fill_inc;
    slot_new = (fill_count != '0) ? slot_inc(newest_slot) : newest_slot;
  end

  // zoom ratio only applies when the views differ and the reference is set
  assign fov_scale = (cur_fov != reference_fov) && (reference_fov != '0);
  assign read_done = (rd_left == '0) && !rd_vld;
  assign div_last  = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (s_tvalid) state_next = ST_READ;
      ST_READ:     if (read_done) state_next = ST_DIV_AVG;
      ST_DIV_AVG: begin
        if (div_last) state_next = fov_scale ? ST_FOV_MUL : ST_SENS_MUL;
      end
      ST_FOV_MUL:  state_next = ST_DIV_FOV;
      ST_DIV_FOV:  if (div_last) state_next = ST_SENS_MUL;
      ST_SENS_MUL: state_next = ST_GAIN_MUL;
      ST_GAIN_MUL: state_next = ST_SAT;
      ST_SAT:      state_next = ST_STEER;
      ST_STEER:    state_next = ST_WRAP;
      ST_WRAP:     state_next = ST_DONE;
      ST_DONE:     if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    s_tready = (state == ST_IDLE);
    rd_en    = (state == ST_READ) && (rd_left != '0);
    out_load = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  assign accept = s_tvalid && s_tready;

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      filter_enable    <= 1'b1;
      filter_frames    <= 5'd2;
      reference_fov    <= 8'd90;
      sensitivity      <= 16'd102;
      yaw_gain         <= 16'd256;
      pitch_gain       <= 16'hFF00;
      pitch_limit_down <= 15'd20480;
      pitch_limit_up   <= 15'd20480;
      fill_count       <= '0;
      newest_slot      <= '0;
      rd_left          <= '0;
      rd_vld           <= 1'b0;
      div_cnt          <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;

      if (accept) begin
        fill_count  <= fill_new;
        newest_slot <= slot_new;
        rd_left     <= filter_enable ? fill_new - 1'b1 : '0;
      end else if (rd_en) begin
        rd_left <= rd_left - 1'b1;
      end

      // divider step count, restarted whenever a division is loaded
      if ((state == ST_DIV_AVG) || (state == ST_DIV_FOV)) begin
        div_cnt <= div_cnt + 1'b1;
      end else begin
        div_cnt <= '0;
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_FILTER_ENABLE:    filter_enable <= cfg_data[0];
          CFG_FILTER_FRAMES: begin
            filter_frames <= cfg_data[4:0];
            fill_count    <= '0;
          end
          CFG_REFERENCE_FOV:    reference_fov    <= cfg_data[7:0];
          CFG_SENSITIVITY:      sensitivity      <= cfg_data;
          CFG_YAW_GAIN:         yaw_gain         <= cfg_data;
          CFG_PITCH_GAIN:       pitch_gain       <= cfg_data;
          CFG_PITCH_LIMIT_DOWN: pitch_limit_down <= cfg_data[14:0];
          CFG_PITCH_LIMIT_UP:   pitch_limit_up   <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // history ring: written at accept, older slots read one per cycle after it;
  // reads never hit the slot written for the current beat, so no forwarding
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      hist_mem[slot_new] <= s_tdata[31:0];
    end
    if (rd_en) begin
      rd_data <= hist_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // lane arithmetic
  // --------------------------------------------------------------------------
  assign lane_gain[0] = yaw_gain;
  assign lane_gain[1] = pitch_gain;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sum_abs[i]   = sum[i][SUM_W-1] ? (SUM_W-1)'(-sum[i]) : sum[i][SUM_W-2:0];
      // two restoring steps per cycle, divisor at most eight bits
      div_a[i]     = div_step(rem[i], dq[i][DIV_W-1], den);
      div_b[i]     = div_step(div_a[i][DEN_W-1:0], dq[i][DIV_W-2], den);
      sens_prod[i] = 47'(dq[i][30:0]) * 47'(sensitivity);
      gmag[i]      = lane_gain[i][15] ? 16'(-lane_gain[i]) : lane_gain[i];
      // anything at or above 2^31 saturates for any nonzero gain
      mag_clamp[i] = (|mag[i][MAG_W-1:31]) ? MAG_CAP : mag[i][31:0];
      gain_prod[i] = PROD_W'(mag_clamp[i]) * PROD_W'(gmag[i]);
      prod_sh[i]   = prod[i][PROD_W-1:8];
      move_lim[i]  = fsgn[i] ? MOVE_NEG_MAG : MOVE_POS_MAG;
      move_mag[i]  = (prod_sh[i] > 40'(move_lim[i])) ? move_lim[i] : prod_sh[i][MOVE_W-1:0];
    end
  end

  // yaw moves against the pointer, pitch with it; pitch clamps in order
  always_comb begin
    lim_dn    = $signed({{(ANGLE_W-15){1'b0}}, pitch_limit_down});
    lim_up    = -$signed({{(ANGLE_W-15){1'b0}}, pitch_limit_up});
    pitch_sum = $signed({{(ANGLE_W-17){pitch_in[16]}}, pitch_in})
              + $signed({move[1][MOVE_W-1], move[1]});
    if (!steer) begin
      pitch_res = pitch_in;
    end else if (pitch_sum < lim_up) begin
      pitch_res = lim_up[16:0];
    end else if (pitch_sum > lim_dn) begin
      pitch_res = (lim_dn < lim_up) ? lim_up[16:0] : lim_dn[16:0];
    end else begin
      pitch_res = pitch_sum[16:0];
    end
  end

  // --------------------------------------------------------------------------
  // payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_fov  <= s_tdata[39:32];
      yaw_in   <= s_tdata[56:40];
      pitch_in <= s_tdata[73:57];
      steer    <= s_tuser;
      rd_addr  <= slot_dec(slot_new);
      div_n    <= filter_enable ? fill_new : FILL_W'(1);
      // newest sample seeds the sums
      sum[0]   <= SUM_W'($signed(s_tdata[15:0]));
      sum[1]   <= SUM_W'($signed(s_tdata[31:16]));
    end

    if (rd_en) begin
      rd_addr <= slot_dec(rd_addr);
    end

    if (rd_vld) begin
      sum[0] <= sum[0] + SUM_W'($signed(rd_data[15:0]));
      sum[1] <= sum[1] + SUM_W'($signed(rd_data[31:16]));
    end

    // average: |sum| * 256 / n
    if ((state == ST_READ) && read_done) begin
      den <= DEN_W'(div_n);
      for (int i = 0; i < LANES; i++) begin
        dq[i]  <= {{(DIV_W-SUM_W-7){1'b0}}, sum_abs[i], 8'h00};
        rem[i] <= '0;
        sgn[i] <= sum[i][SUM_W-1];
      end
    end

    if ((state == ST_DIV_AVG) || (state == ST_DIV_FOV)) begin
      for (int i = 0; i < LANES; i++) begin
        dq[i]  <= {dq[i][DIV_W-3:0], div_a[i][DEN_W], div_b[i][DEN_W]};
        rem[i] <= div_b[i][DEN_W-1:0];
      end
    end

    // zoom: m * fov, then divided by the reference
    if (state == ST_FOV_MUL) begin
      den <= reference_fov;
      for (int i = 0; i < LANES; i++) begin
        dq[i]  <= DIV_W'(dq[i][23:0]) * DIV_W'(cur_fov);
        rem[i] <= '0;
      end
    end

    if (state == ST_SENS_MUL) begin
      for (int i = 0; i < LANES; i++) begin
        mag[i] <= (sensitivity != '0) ? sens_prod[i][46:8] : MAG_W'(dq[i]);
      end
    end

    if (state == ST_GAIN_MUL) begin
      for (int i = 0; i < LANES; i++) begin
        prod[i] <= gain_prod[i];
        fsgn[i] <= sgn[i] ^ lane_gain[i][15];
      end
    end

    if (state == ST_SAT) begin
      for (int i = 0; i < LANES; i++) begin
        move[i] <= fsgn[i] ? MOVE_W'(-move_mag[i]) : move_mag[i];
      end
    end

    if (state == ST_STEER) begin
      if (steer) begin
        yaw_v <= $signed({{(ANGLE_W-17){1'b0}}, yaw_in})
               - $signed({move[0][MOVE_W-1], move[0]});
      end else begin
        yaw_v <= $signed({{(ANGLE_W-17){1'b0}}, yaw_in});
      end
      pitch_in <= pitch_res;
    end

    if (state == ST_WRAP) begin
      yaw_res <= wrap_yaw(yaw_v);
    end

    if (out_load) begin
      m_tdata <= {6'b0, pitch_in, yaw_res, move[1], move[0]};
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  `CHECK_PROP(a_fill_in_window, fill_count <= win_len, "fill count beyond window")
  `CHECK_PROP(a_read_not_newest, !rd_en || (rd_addr != newest_slot), "read hits newest slot")
  `CHECK_NEXT(a_accept_reads, accept, state == ST_READ, "accept did not start reads")
  `CHECK_PROP(a_result_from_done, !$rose(m_tvalid) || ($past(state) == ST_DONE), "stray result")

endmodule

`default_nettype wire
